// ===== sv/mpfe_pkg.sv =====
// shared types, constants and helpers for the multicast pixel frame extractor
// no dependencies

package mpfe_pkg;

   localparam int PACKET_BYTES = 314;
   localparam int POS_W        = 10;
   localparam int BASE_W       = 9;

   localparam logic [7:0]       FRAME_TAG  = 8'h01;
   localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(PACKET_BYTES);
   localparam logic [3:0]       WINDOW_LEN = 4'd12;

   // register indexes on the csr port
   localparam logic REG_FLOOR = 1'b0;
   localparam logic REG_ROOM  = 1'b1;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       window_side;
      logic [1:0] pixel_index;
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
   } rsp_type;

   // slot derived from floor and room
   typedef struct packed {
      logic              regs_nonzero;
      logic              idx_ok;
      logic [3:0]        quotient;
      logic [BASE_W-1:0] base;
   } slot_type;

   typedef struct packed {
      logic [1:0] group;
      logic [1:0] phase;
   } split_type;

   // rel / 3 and rel % 3 for the twelve window bytes
   function automatic split_type split_rel(input logic [3:0] rel);
      split_type s;
      case (rel)
         4'd0:    s = '{group: 2'd0, phase: 2'd0};
         4'd1:    s = '{group: 2'd0, phase: 2'd1};
         4'd2:    s = '{group: 2'd0, phase: 2'd2};
         4'd3:    s = '{group: 2'd1, phase: 2'd0};
         4'd4:    s = '{group: 2'd1, phase: 2'd1};
         4'd5:    s = '{group: 2'd1, phase: 2'd2};
         4'd6:    s = '{group: 2'd2, phase: 2'd0};
         4'd7:    s = '{group: 2'd2, phase: 2'd1};
         4'd8:    s = '{group: 2'd2, phase: 2'd2};
         4'd9:    s = '{group: 2'd3, phase: 2'd0};
         4'd10:   s = '{group: 2'd3, phase: 2'd1};
         4'd11:   s = '{group: 2'd3, phase: 2'd2};
         default: s = '{group: 2'd0, phase: 2'd0};
      endcase
      return s;
   endfunction

   function automatic logic [7:0] level(input logic [3:0] nib);
      return {nib[2:0], 5'b0};
   endfunction

endpackage

// ===== sv/mpfe_csr.sv =====
// floor and room registers behind the csr port, plus the registered slot
// derivation (index, quotient by 26, window base); uses mpfe_pkg

module mpfe_csr import mpfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output slot_type    slot
);

   logic [7:0]  floor_ff, floor_in;
   logic [7:0]  room_ff, room_in;
   slot_type    slot_ff, slot_in;
   logic        wr_en;
   logic [11:0] idx;
   logic [8:0]  idx_u;
   logic [17:0] prod;
   logic [3:0]  quot;
   logic [8:0]  rem_full;
   logic [4:0]  rem;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      floor_in = floor_ff;
      room_in  = room_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_FLOOR: floor_in = pwdata[7:0];
            REG_ROOM:  room_in  = pwdata[7:0];
            default:   floor_in = floor_ff;
         endcase
      end
   end

   // idx = (18 - floor) * 8 + (room - 5) = 139 + room - 8 * floor
   always_comb begin
      idx      = 12'd139 + {4'd0, room_in} - {1'b0, floor_in, 3'b0};
      idx_u    = idx[8:0];
      // 631 / 16384 gives the exact quotient by 26 for idx up to 394
      prod     = 18'(idx_u * 10'd631);
      quot     = prod[17:14];
      rem_full = idx_u - 9'(quot * 5'd26);
      rem      = rem_full[4:0];
      slot_in.regs_nonzero = (floor_in != 8'd0) && (room_in != 8'd0);
      slot_in.idx_ok       = ~idx[11];
      slot_in.quotient     = quot;
      slot_in.base         = BASE_W'(rem * 4'd12) + BASE_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
         room_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         floor_ff <= floor_in;
         room_ff  <= room_in;
         slot_ff  <= slot_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FLOOR: prdata = {24'd0, floor_ff};
         REG_ROOM:  prdata = {24'd0, room_ff};
         default:   prdata = '0;
      endcase
   end

   assign slot = slot_ff;

endmodule

// ===== sv/mpfe_pixel.sv =====
// per-byte decode: header checks, window test and pixel assembly
// purely combinational; uses mpfe_pkg

module mpfe_pixel import mpfe_pkg::*; (
   input  slot_type         slot,
   input  logic [POS_W-1:0] pos,
   input  logic             accepted,
   input  logic [7:0]       held,
   input  logic [7:0]       cur,
   output logic             accepted_next,
   output logic             emit,
   output rsp_type          pixel
);

   logic [POS_W-1:0] rel_full;
   logic [3:0]       rel;
   logic             in_window;
   split_type        sp;
   logic [2:0]       pix;
   logic [7:0]       cur_m1;

   always_comb begin
      cur_m1    = cur - 8'd1;
      rel_full  = pos - POS_W'(slot.base);
      rel       = rel_full[3:0];
      in_window = (pos >= POS_W'(slot.base)) && (rel_full < POS_W'(WINDOW_LEN));
      sp        = split_rel(rel);
      pix       = {sp.group, 1'b0};

      accepted_next = accepted;
      emit          = 1'b0;
      pixel         = '0;

      if (pos == '0) begin
         accepted_next = (cur == FRAME_TAG);
      end else if (pos == POS_W'(1)) begin
         accepted_next = accepted && slot.regs_nonzero && slot.idx_ok
                         && (cur_m1 == {4'd0, slot.quotient});
      end else if (accepted && slot.idx_ok && (pos < POS_LIMIT) && in_window) begin
         case (sp.phase)
            2'd1: begin
               emit              = 1'b1;
               pixel.red_level   = level(held[7:4]);
               pixel.green_level = level(held[3:0]);
               pixel.blue_level  = level(cur[7:4]);
            end
            2'd2: begin
               emit              = 1'b1;
               pix               = {sp.group, 1'b1};
               pixel.red_level   = level(held[3:0]);
               pixel.green_level = level(cur[7:4]);
               pixel.blue_level  = level(cur[3:0]);
            end
            default: emit = 1'b0;
         endcase
         pixel.window_side = pix[2];
         pixel.pixel_index = pix[1:0];
      end
   end

endmodule

// ===== sv/multicast_pixel_frame_extractor_core.sv =====
// Multicast pixel frame extractor: frame datagram bytes in, pixels out.
// Depends on mpfe_pkg, mpfe_csr and mpfe_pixel.
//
// Usage
//   req channel: one datagram byte per transfer, last_byte marks the end of
//   a datagram; the following byte opens a new packet.
//   rsp channel: one pixel per transfer, left window pixels 0..3 first, then
//   the right window, each channel level holding a nibble's low three bits.
//   csr port: floor_number at address 0, room_number at address 4; either
//   at zero disables acceptance. Write only while the block is idle.
// Pipeline and throughput
//   an accepted byte is decoded from the input register into the result
//   register, from which its pixel shows on rsp. One byte per cycle is
//   sustained while rsp is not stalled; the input register, the packet
//   state and the result register form a two-stage pipeline.
// Reset
//   clears both registers, the packet position and acceptance flag, and
//   empties both pipeline stages.
// Receiver stall
//   the result register holds its pixel; one further byte waits in the
//   input register and req_ready drops until rsp_ready returns.

module multicast_pixel_frame_extractor_core import mpfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   slot_type         slot;
   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff, in_data_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             accepted_ff, accepted_in;
   logic [7:0]       held_ff, held_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;
   logic             out_free;
   logic             advance;
   logic             accepted_next;
   logic             emit;
   rsp_type          pixel;

   mpfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .slot    (slot)
   );

   mpfe_pixel u_pixel (
      .slot          (slot),
      .pos           (pos_ff),
      .accepted      (accepted_ff),
      .held          (held_ff),
      .cur           (in_data_ff.packet_byte),
      .accepted_next (accepted_next),
      .emit          (emit),
      .pixel         (pixel)
   );

   assign out_free  = ~out_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      pos_in       = pos_ff;
      accepted_in  = accepted_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         held_in     = in_data_ff.packet_byte;
         if (in_data_ff.last_byte) begin
            pos_in      = '0;
            accepted_in = 1'b0;
         end else begin
            accepted_in = accepted_next;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         if (emit) begin
            out_valid_in = 1'b1;
            out_data_in  = pixel;
         end
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         accepted_ff  <= 1'b0;
         held_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         accepted_ff  <= accepted_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== sv/mpfe_checker.sv =====
// port-level checks for multicast_pixel_frame_extractor_core
// uses mpfe_pkg; attached to the top level by the bind at the end

module mpfe_checker import mpfe_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    pready
);

   // a stalled pixel stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp pixel changed while stalled");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // levels only carry bits 7..5
   a_level_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red_level[4:0] == 5'd0)
                    && (rsp_data.green_level[4:0] == 5'd0)
                    && (rsp_data.blue_level[4:0] == 5'd0))
      else $error("pixel level has low bits set");

   // a new pixel needs an earlier byte transfer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("pixel appeared without a byte transfer");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind multicast_pixel_frame_extractor_core mpfe_checker u_mpfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);
